### sv/egpf_pkg.sv
// Shared widths, register addresses and reset values for the ellipsoidal grain profile factor block.
`default_nettype none

package egpf_pkg;

    // Fixed field widths
    localparam int Z_W      = 32;   // z_position, signed Q15.16
    localparam int H_W      = 31;   // film_height
    localparam int FRAC_W   = 17;   // rounding_strength, origin_fraction
    localparam int RES_W    = 17;   // scale_factor
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 4;

    // Register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_ROUNDING = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_ORIGIN   = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_FILM     = 4'h8;

    // Reset values
    localparam logic [FRAC_W-1:0] ROUNDING_RST = 17'd0;
    localparam logic [FRAC_W-1:0] ORIGIN_RST   = 17'd32768;
    localparam logic [H_W-1:0]    FILM_RST     = 31'd0;

endpackage

`default_nettype wire

### sv/ellipsoidal_grain_profile_factor.sv
// Top level: pipelined ellipsoidal grain profile factor with APB configuration.
//
// Usage
//   Configure rounding_strength (0x0), origin_fraction (0x4) and film_height (0x8)
//   through the APB port while no transaction is in flight; pready is tied high.
//   Each input transaction carries one z_position; each yields exactly one output
//   transaction with scale_factor and beyond_pole, in order.
// Pipeline and throughput
//   The datapath is a pipeline of 2*FRACTION_BITS+6 register stages (38 at the
//   default): capture, semi-axis select, FRACTION_BITS restoring division steps,
//   a squaring stage, FRACTION_BITS+1 square root digit steps, a multiply stage
//   and an output stage. One transaction is accepted per cycle unless the output stalls.
// Reset
//   rst_n clears all valid bits and loads the register reset values.
// Stall
//   Each stage holds while the one after it is full and stalled; empty stages
//   keep filling, so in_ready drops only once the whole pipeline is full.
`default_nettype none

module ellipsoidal_grain_profile_factor
    import egpf_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // APB configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready,
    // Input channel
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [Z_W-1:0]      z_position,
    // Output channel
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [RES_W-1:0]    scale_factor,
    output logic                     beyond_pole
);

    localparam int F      = FRACTION_BITS;
    localparam int LW     = F + 1;
    localparam int V_W    = 2 * F + 2;
    localparam int SR_W   = F + 4;
    localparam int P_W    = 2 * LW;
    localparam int N      = 2 * F + 6;
    localparam int SQ_S   = F + 2;
    localparam int RT0    = F + 3;
    localparam int MUL_S  = 2 * F + 4;
    localparam int OUT_S  = 2 * F + 5;

    localparam logic [31:0]    ONE_32 = 32'd1 << F;
    localparam logic [LW-1:0]  ONE    = LW'(ONE_32);
    localparam logic [V_W-1:0] ONE_SQ = V_W'(1) << (2 * F);
    localparam logic [P_W-1:0] HALF   = P_W'(ONE_32 >> 1);

    typedef struct packed {
        logic [Z_W-1:0]  zz;
        logic            byp;
        logic            flag;
        logic [LW-1:0]   res;
        logic [H_W-1:0]  c;
        logic [H_W-1:0]  rem;
        logic [F-1:0]    q;
        logic [V_W-1:0]  v;
        logic [SR_W-1:0] sr;
        logic [LW-1:0]   root;
        logic [P_W-1:0]  p;
    } pl_t;

    // Configuration registers
    logic [FRAC_W-1:0] rounding_strength_reg;
    logic [FRAC_W-1:0] origin_fraction_reg;
    logic [H_W-1:0]    film_height_reg;
    logic [H_W-1:0]    z0_reg;
    logic [H_W-1:0]    z0_next;
    logic [LW-1:0]     lam;
    logic [LW-1:0]     frac;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounding_strength_reg <= ROUNDING_RST;
            origin_fraction_reg   <= ORIGIN_RST;
            film_height_reg       <= FILM_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                ADDR_ROUNDING: rounding_strength_reg <= pwdata[FRAC_W-1:0];
                ADDR_ORIGIN:   origin_fraction_reg   <= pwdata[FRAC_W-1:0];
                ADDR_FILM:     film_height_reg       <= pwdata[H_W-1:0];
                default:       ;
            endcase
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (paddr)
            ADDR_ROUNDING: prdata = PDATA_W'(rounding_strength_reg);
            ADDR_ORIGIN:   prdata = PDATA_W'(origin_fraction_reg);
            ADDR_FILM:     prdata = PDATA_W'(film_height_reg);
            default:       prdata = '0;
        endcase
    end

    // Saturated strength and origin fraction
    assign lam  = (32'(rounding_strength_reg) > ONE_32) ? ONE : LW'(32'(rounding_strength_reg));
    assign frac = (32'(origin_fraction_reg) > ONE_32) ? ONE : LW'(32'(origin_fraction_reg));

    // Registered origin height; keep config static while items in flight (unchecked)
    assign z0_next = H_W'(((H_W + LW)'(film_height_reg) * (H_W + LW)'(frac)) >> F);

    always_ff @(posedge clk)
    begin
        z0_reg <= z0_next;
    end

    // Pipeline
    pl_t  pipe_reg  [N];
    pl_t  pipe_next [N];
    logic valid_reg [N];
    logic adv       [N+1];

    always_comb
    begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        if (k == 0)
        begin : g_cap
            always_comb
            begin
                pipe_next[k]    = pipe_reg[k];
                pipe_next[k].zz = z_position;
            end
        end
        else if (k == 1)
        begin : g_axis
            always_comb
            begin
                logic signed [32:0] zs;
                logic signed [32:0] z0s;
                logic [32:0]        d;
                logic [H_W-1:0]     c;
                logic               sp;
                pipe_next[k] = pipe_reg[k-1];
                zs  = {pipe_reg[k-1].zz[Z_W-1], pipe_reg[k-1].zz};
                z0s = {2'b00, z0_reg};
                if (zs >= z0s)
                begin
                    c = film_height_reg - z0_reg;
                    d = 33'(zs - z0s);
                end
                else
                begin
                    c = z0_reg;
                    d = 33'(z0s - zs);
                end
                sp = (c == '0) || (d >= {2'b00, c});
                pipe_next[k].byp  = (lam == '0) || sp;
                pipe_next[k].flag = (lam != '0) && sp;
                pipe_next[k].res  = (lam == '0) ? ONE : ONE - lam;
                pipe_next[k].c    = c;
                pipe_next[k].rem  = d[H_W-1:0];
                pipe_next[k].q    = '0;
            end
        end
        else if (k < SQ_S)
        begin : g_div
            // One restoring division step per stage
            always_comb
            begin
                logic [H_W:0] t;
                pipe_next[k] = pipe_reg[k-1];
                t = {pipe_reg[k-1].rem, 1'b0};
                if (t >= {1'b0, pipe_reg[k-1].c})
                begin
                    pipe_next[k].rem = H_W'(t - {1'b0, pipe_reg[k-1].c});
                    pipe_next[k].q   = {pipe_reg[k-1].q[F-2:0], 1'b1};
                end
                else
                begin
                    pipe_next[k].rem = t[H_W-1:0];
                    pipe_next[k].q   = {pipe_reg[k-1].q[F-2:0], 1'b0};
                end
            end
        end
        else if (k == SQ_S)
        begin : g_sq
            always_comb
            begin
                logic [2*F-1:0] sq;
                pipe_next[k] = pipe_reg[k-1];
                sq = pipe_reg[k-1].q * pipe_reg[k-1].q;
                pipe_next[k].v    = ONE_SQ - V_W'(sq);
                pipe_next[k].sr   = '0;
                pipe_next[k].root = '0;
            end
        end
        else if (k < MUL_S)
        begin : g_root
            // One square root digit per stage
            always_comb
            begin
                logic [SR_W-1:0] rs;
                logic [SR_W-1:0] trial;
                pipe_next[k] = pipe_reg[k-1];
                rs    = {pipe_reg[k-1].sr[SR_W-3:0],
                         pipe_reg[k-1].v[V_W-1-2*(k-RT0) -: 2]};
                trial = {1'b0, pipe_reg[k-1].root, 2'b01};
                if (rs >= trial)
                begin
                    pipe_next[k].sr   = rs - trial;
                    pipe_next[k].root = {pipe_reg[k-1].root[LW-2:0], 1'b1};
                end
                else
                begin
                    pipe_next[k].sr   = rs;
                    pipe_next[k].root = {pipe_reg[k-1].root[LW-2:0], 1'b0};
                end
            end
        end
        else if (k == MUL_S)
        begin : g_mul
            always_comb
            begin
                logic [LW-1:0] e;
                pipe_next[k] = pipe_reg[k-1];
                e = (pipe_reg[k-1].root > ONE) ? ONE : pipe_reg[k-1].root;
                pipe_next[k].p = P_W'(lam) * P_W'(ONE - e);
            end
        end
        else
        begin : g_out
            always_comb
            begin
                logic [P_W-1:0] prod;
                pipe_next[k] = pipe_reg[k-1];
                prod = (pipe_reg[k-1].p + HALF) >> F;
                if (!pipe_reg[k-1].byp)
                begin
                    pipe_next[k].res = (prod > P_W'(ONE)) ? '0 : ONE - prod[LW-1:0];
                end
            end
        end

        // Stage registers
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv[k])
            begin
                valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && ((k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1]))
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign out_valid    = valid_reg[OUT_S];
    assign scale_factor = RES_W'(pipe_reg[OUT_S].res);
    assign beyond_pole  = pipe_reg[OUT_S].flag;

    // Assertions
    a_pole_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && beyond_pole) |-> (scale_factor == RES_W'(ONE - lam)))
        else $error("pole result is not one minus strength");

    a_zero_strength: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && lam == '0) |-> (scale_factor == RES_W'(ONE) && !beyond_pole))
        else $error("zero strength must give unity without flag");

    a_flag_needs_strength: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && beyond_pole) |-> (lam != '0))
        else $error("pole flag raised with zero strength");

endmodule

`default_nettype wire
